@@ rtl/cltok_pkg.sv @@
package cltok_pkg;

    localparam int MAX_TEXT_LEN_DEF = 4096;
    localparam int FIELD_W          = 13;

    localparam logic [1:0] MODE_BETWEEN = 2'd0;
    localparam logic [1:0] MODE_WORD    = 2'd1;
    localparam logic [1:0] MODE_STRING  = 2'd2;

    localparam logic [2:0] KIND_STRING = 3'd3;
    localparam logic [2:0] KIND_END    = 3'd4;
    localparam logic [2:0] KIND_ERROR  = 3'd5;

    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_EMPTY        = 3'd1;
    localparam logic [2:0] ERR_DIGIT        = 3'd2;
    localparam logic [2:0] ERR_SYMBOL       = 3'd3;
    localparam logic [2:0] ERR_EMPTY_STRING = 3'd4;
    localparam logic [2:0] ERR_UNTERMINATED = 3'd5;
    localparam logic [2:0] ERR_LONE_DDASH   = 3'd6;
    localparam logic [2:0] ERR_LONE_DASH    = 3'd7;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    typedef struct packed {
        logic                 last_of_run;
        logic                 final_res;
        logic [FIELD_W-1:0]   length;
        logic [FIELD_W-1:0]   pos;
        logic [2:0]           error_code;
        logic [2:0]           kind;
    } res_t;

    function automatic res_t make_res(input logic [2:0] kind, input logic [2:0] code,
                                      input logic [FIELD_W-1:0] pos,
                                      input logic [FIELD_W-1:0] len, input logic fin);
        res_t r;
        r.kind        = kind;
        r.error_code  = code;
        r.pos         = pos;
        r.length      = len;
        r.final_res   = fin;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

@@ rtl/command_line_tokenizer_core.sv @@
// An accepted beat is held in an input register; when it is processed, its results are written
// into the result queue, whose head entry drives the output combinationally.
// Throughput: one input beat per cycle while each beat yields at most one result and
// m_tready stays high; a beat yielding two results (token plus end) writes both into the queue at once.
// The four-entry result queue sets the stall point: input is processed only
// while at least two entries are free.
// Reset (aresetn low, synchronous) clears the tokenizer state and empties the queue.
module command_line_tokenizer_core #(
    parameter int MAX_TEXT_LEN = cltok_pkg::MAX_TEXT_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch
    input  logic        s_tuser,   // has_char
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // kind[2:0], error_code[5:3], pos[18:6], length[31:19]
    output logic        m_tuser,   // final_res
    output logic        m_tlast    // last_of_run
);
    import cltok_pkg::*;

    localparam int PW    = $clog2(MAX_TEXT_LEN + 1);
    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    function automatic logic [FIELD_W-1:0] to_field(input logic [PW-1:0] v);
        logic [PW+FIELD_W-1:0] e;
        e = {{FIELD_W{1'b0}}, v};
        return e[FIELD_W-1:0];
    endfunction

    logic          in_valid_reg;
    logic [7:0]    ch_reg;
    logic          has_reg;
    logic          last_reg;

    logic [1:0]    mode_reg, mode_next;
    logic [PW-1:0] position_reg, position_next;
    logic [PW-1:0] tstart_reg, tstart_next;
    logic [1:0]    dash_reg, dash_next;
    logic          ident_reg, ident_next;
    logic          sne_reg, sne_next;
    logic          err_reg, err_next;

    res_t          r0, r1;
    logic [1:0]    n;
    logic          is_digit, is_alnum, ident_ok;

    res_t          fifo_mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   cnt_reg;
    logic          fire, pop;

    assign fire     = in_valid_reg && (cnt_reg <= (AW+1)'(DEPTH - 2));
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = (cnt_reg != '0);
    assign pop      = m_tvalid && m_tready;

    assign is_digit = (ch_reg >= 8'h30) && (ch_reg <= 8'h39);
    assign is_alnum = is_digit || ((ch_reg >= 8'h61) && (ch_reg <= 8'h7A))
                      || ((ch_reg >= 8'h41) && (ch_reg <= 8'h5A));
    assign ident_ok = is_alnum || (ch_reg == CH_DASH);

    always_comb begin
        res_t rr;
        mode_next     = mode_reg;
        position_next = position_reg;
        tstart_next   = tstart_reg;
        dash_next     = dash_reg;
        ident_next    = ident_reg;
        sne_next      = sne_reg;
        err_next      = err_reg;
        r0 = '0;
        r1 = '0;
        n  = 2'd0;
        rr = '0;

        if (!err_reg && has_reg && (position_reg < PW'(MAX_TEXT_LEN))) begin
            case (mode_reg)
                MODE_BETWEEN: begin
                    if (ch_reg == CH_QUOTE) begin
                        mode_next   = MODE_STRING;
                        tstart_next = position_reg;
                        sne_next    = 1'b0;
                    end else if (ch_reg != CH_SPACE) begin
                        mode_next   = MODE_WORD;
                        tstart_next = position_reg;
                        ident_next  = 1'b0;
                        if (ch_reg == CH_DASH) begin
                            dash_next = 2'd1;
                        end else begin
                            dash_next = 2'd0;
                            if (is_digit) begin
                                r0 = make_res(KIND_ERROR, ERR_DIGIT, to_field(position_reg),
                                              '0, 1'b1);
                                n = 2'd1;
                                err_next = 1'b1;
                            end else if (!ident_ok) begin
                                r0 = make_res(KIND_ERROR, ERR_SYMBOL, to_field(position_reg),
                                              '0, 1'b1);
                                n = 2'd1;
                                err_next = 1'b1;
                            end else begin
                                ident_next = 1'b1;
                            end
                        end
                    end
                end
                MODE_WORD: begin
                    if (ch_reg == CH_SPACE) begin
                        mode_next = MODE_BETWEEN;
                        if (!ident_reg) begin
                            r0 = make_res(KIND_ERROR,
                                          (dash_reg == 2'd2) ? ERR_LONE_DDASH : ERR_LONE_DASH,
                                          to_field(tstart_reg), '0, 1'b1);
                            err_next = 1'b1;
                        end else begin
                            r0 = make_res({1'b0, dash_reg}, ERR_NONE, to_field(tstart_reg),
                                          to_field(position_reg - tstart_reg), 1'b0);
                        end
                        n = 2'd1;
                    end else if (dash_reg == 2'd1 && !ident_reg && ch_reg == CH_DASH) begin
                        dash_next = 2'd2;
                    end else if (!ident_reg && is_digit) begin
                        r0 = make_res(KIND_ERROR, ERR_DIGIT, to_field(tstart_reg), '0, 1'b1);
                        n = 2'd1;
                        err_next = 1'b1;
                    end else if (!ident_ok) begin
                        r0 = make_res(KIND_ERROR, ERR_SYMBOL, to_field(tstart_reg), '0, 1'b1);
                        n = 2'd1;
                        err_next = 1'b1;
                    end else begin
                        ident_next = 1'b1;
                    end
                end
                default: begin
                    if (ch_reg == CH_QUOTE) begin
                        mode_next = MODE_BETWEEN;
                        if (!sne_reg) begin
                            r0 = make_res(KIND_ERROR, ERR_EMPTY_STRING, to_field(tstart_reg),
                                          '0, 1'b1);
                            err_next = 1'b1;
                        end else begin
                            r0 = make_res(KIND_STRING, ERR_NONE,
                                          to_field(position_reg + PW'(1)),
                                          to_field(position_reg - tstart_reg - PW'(1)), 1'b0);
                        end
                        n = 2'd1;
                    end else begin
                        sne_next = 1'b1;
                    end
                end
            endcase
            position_next = position_reg + PW'(1);
        end

        if (last_reg && !err_next) begin
            if (position_next == '0) begin
                r0 = make_res(KIND_ERROR, ERR_EMPTY, '0, '0, 1'b1);
                n = 2'd1;
            end else begin
                rr = make_res(KIND_END, ERR_NONE, to_field(position_next), '0, 1'b1);
                if (mode_next == MODE_WORD) begin
                    if (!ident_next) begin
                        rr = make_res(KIND_ERROR,
                                      (dash_next == 2'd2) ? ERR_LONE_DDASH : ERR_LONE_DASH,
                                      to_field(tstart_next), '0, 1'b1);
                    end else begin
                        r0 = make_res({1'b0, dash_next}, ERR_NONE, to_field(tstart_next),
                                      to_field(position_next - tstart_next), 1'b0);
                        n = 2'd1;
                    end
                end else if (mode_next == MODE_STRING) begin
                    rr = make_res(KIND_ERROR, ERR_UNTERMINATED, to_field(tstart_next),
                                  '0, 1'b1);
                end
                if (n == 2'd0) begin
                    r0 = rr;
                    n  = 2'd1;
                end else begin
                    r1 = rr;
                    n  = 2'd2;
                end
            end
        end

        if (n == 2'd1) begin
            r0.last_of_run = 1'b1;
        end
        if (n == 2'd2) begin
            r1.last_of_run = 1'b1;
        end

        if (last_reg) begin
            mode_next     = MODE_BETWEEN;
            position_next = '0;
            tstart_next   = '0;
            dash_next     = 2'd0;
            ident_next    = 1'b0;
            sne_next      = 1'b0;
            err_next      = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            ch_reg   <= s_tdata;
            has_reg  <= s_tuser;
            last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_BETWEEN;
            position_reg <= '0;
            tstart_reg   <= '0;
            dash_reg     <= 2'd0;
            ident_reg    <= 1'b0;
            sne_reg      <= 1'b0;
            err_reg      <= 1'b0;
        end else if (fire) begin
            mode_reg     <= mode_next;
            position_reg <= position_next;
            tstart_reg   <= tstart_next;
            dash_reg     <= dash_next;
            ident_reg    <= ident_next;
            sne_reg      <= sne_next;
            err_reg      <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && n != 2'd0) begin
            fifo_mem[wr_ptr_reg] <= r0;
        end
        if (fire && n == 2'd2) begin
            fifo_mem[wr_ptr_reg + AW'(1)] <= r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (fire) begin
                wr_ptr_reg <= wr_ptr_reg + AW'(n);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            cnt_reg <= cnt_reg + (fire ? (AW+1)'(n) : '0) - (pop ? (AW+1)'(1) : '0);
        end
    end

    always_comb begin
        res_t head;
        head    = fifo_mem[rd_ptr_reg];
        m_tdata = {head.length, head.pos, head.error_code, head.kind};
        m_tuser = head.final_res;
        m_tlast = head.last_of_run;
    end

endmodule
